// ----- rtl/core/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the span fill core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
		else $error("assertion failed");

// antecedent in this cycle implies consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/core/atsf_pkg.sv -----
// ----------------------------------------------------------------------------
// atsf_pkg
// shared constants and types of the active triangle span fill core
// ----------------------------------------------------------------------------
package atsf_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
	localparam int ID_W        = 8;
	localparam int COLOR_W     = 32;

	localparam logic           REQ_CROSS = 1'b0;
	localparam logic           REQ_PIXEL = 1'b1;
	localparam logic [COLOR_W-1:0] NO_COLOR = 32'h0000_0000;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} atsf_state_t;

	typedef struct packed {
		logic capture;
		logic toggle;
		logic pixel;
	} atsf_cmd_t;

	typedef struct packed {
		logic is_pixel;
	} atsf_sts_t;

endpackage

// ----- rtl/core/atsf_req_if.sv -----
// ----------------------------------------------------------------------------
// atsf_req_if
// request channel: crossing or pixel request with valid/ready handshake
// ----------------------------------------------------------------------------
interface atsf_req_if;
	import atsf_pkg::*;

	logic               valid;
	logic               ready;
	logic               req_type;
	logic [ID_W-1:0]    triangle_id;
	logic [COLOR_W-1:0] tri_color;

	modport source (output valid, req_type, triangle_id, tri_color, input ready);
	modport sink   (input valid, req_type, triangle_id, tri_color, output ready);

endinterface

// ----- rtl/core/atsf_res_if.sv -----
// ----------------------------------------------------------------------------
// atsf_res_if
// result channel: pixel color and flags with valid/ready handshake
// ----------------------------------------------------------------------------
interface atsf_res_if;
	import atsf_pkg::*;

	logic               valid;
	logic               ready;
	logic [COLOR_W-1:0] pixel_color;
	logic               covered;
	logic               overflowed;

	modport source (output valid, pixel_color, covered, overflowed, input ready);
	modport sink   (input valid, pixel_color, covered, overflowed, output ready);

endinterface

// ----- rtl/core/atsf_ctrl.sv -----
// ----------------------------------------------------------------------------
// atsf_ctrl
// sequencer: takes a request, runs the execute step, owns result valid
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atsf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output atsf_pkg::atsf_cmd_t cmd,
	input  atsf_pkg::atsf_sts_t sts
);
	import atsf_pkg::*;

	atsf_state_t state_q;
	atsf_state_t state_d;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.capture = 1'b0;
		cmd.toggle  = 1'b0;
		cmd.pixel   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.is_pixel) begin
					cmd.toggle = 1'b1;
					state_d    = ST_IDLE;
				end else if (out_free) begin
					cmd.pixel = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.pixel) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

	`ASSERT_NEXT(a_capture_to_exec, clk, arst_n, cmd.capture, state_q == ST_EXEC)
	`ASSERT_NEXT(a_pixel_sets_valid, clk, arst_n, cmd.pixel, out_valid_q)
	`ASSERT_ALWAYS(a_pixel_needs_slot, clk, arst_n, !cmd.pixel || out_free)

endmodule

// ----- rtl/core/atsf_dpath.sv -----
// ----------------------------------------------------------------------------
// atsf_dpath
// row of stack cells, top at cell zero, with parallel id compare and shift
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module atsf_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  atsf_pkg::atsf_cmd_t           cmd,
	output atsf_pkg::atsf_sts_t           sts,
	input  logic                          req_type,
	input  logic [atsf_pkg::ID_W-1:0]     triangle_id,
	input  logic [atsf_pkg::COLOR_W-1:0]  tri_color,
	output logic [atsf_pkg::COLOR_W-1:0]  pixel_color,
	output logic                          covered,
	output logic                          overflowed
);
	import atsf_pkg::*;

	logic [ID_W-1:0]        ids_q    [STACK_DEPTH];
	logic [COLOR_W-1:0]     colors_q [STACK_DEPTH];
	logic [CNT_W-1:0]       count_q;
	logic                   ovf_q;
	logic                   req_q;
	logic [ID_W-1:0]        id_q;
	logic [COLOR_W-1:0]     color_q;
	logic [STACK_DEPTH-1:0] match_q;
	logic [STACK_DEPTH-1:0] match_d;
	logic [STACK_DEPTH-1:0] hit_le;
	logic                   found;
	logic                   full;
	logic [COLOR_W-1:0]     pixel_color_q;
	logic                   covered_q;
	logic                   overflowed_q;

	// compare against the incoming id, only cells below the fill count
	always_comb begin
		for (int p = 0; p < STACK_DEPTH; p++) begin
			match_d[p] = (CNT_W'(p) < count_q) && (ids_q[p] == triangle_id);
		end
	end

	// cell p closes the gap when the hit sits at or below p
	always_comb begin
		for (int p = 0; p < STACK_DEPTH; p++) begin
			hit_le[p] = |(match_q << (STACK_DEPTH - 1 - p));
		end
	end

	assign found        = |match_q;
	assign full         = (count_q == CNT_W'(STACK_DEPTH));
	assign sts.is_pixel = (req_q == REQ_PIXEL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= '0;
			count_q <= '0;
			ovf_q   <= 1'b0;
			req_q   <= REQ_CROSS;
		end else begin
			if (cmd.capture) begin
				match_q <= match_d;
				req_q   <= req_type;
			end
			if (cmd.toggle) begin
				if (found) begin
					count_q <= count_q - CNT_W'(1);
				end else if (!full) begin
					count_q <= count_q + CNT_W'(1);
				end else begin
					ovf_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			id_q    <= triangle_id;
			color_q <= tri_color;
		end
		if (cmd.pixel) begin
			pixel_color_q <= (count_q != '0) ? colors_q[0] : NO_COLOR;
			covered_q     <= (count_q != '0);
			overflowed_q  <= ovf_q;
		end
	end

	for (genvar p = 0; p < STACK_DEPTH; p++) begin : g_cell
		logic [ID_W-1:0]    up_id;
		logic [COLOR_W-1:0] up_color;
		logic [ID_W-1:0]    dn_id;
		logic [COLOR_W-1:0] dn_color;

		if (p == STACK_DEPTH - 1) begin : g_last
			assign up_id    = ids_q[p];
			assign up_color = colors_q[p];
		end else begin : g_mid
			assign up_id    = ids_q[p+1];
			assign up_color = colors_q[p+1];
		end

		if (p == 0) begin : g_top
			assign dn_id    = id_q;
			assign dn_color = color_q;
		end else begin : g_rest
			assign dn_id    = ids_q[p-1];
			assign dn_color = colors_q[p-1];
		end

		always_ff @(posedge clk) begin
			if (cmd.toggle) begin
				if (found) begin
					if (hit_le[p]) begin
						ids_q[p]    <= up_id;
						colors_q[p] <= up_color;
					end
				end else if (!full) begin
					ids_q[p]    <= dn_id;
					colors_q[p] <= dn_color;
				end
			end
		end
	end

	assign pixel_color = pixel_color_q;
	assign covered     = covered_q;
	assign overflowed  = overflowed_q;

	`ASSERT_ALWAYS(a_single_match, clk, arst_n, $onehot0(match_q))
	`ASSERT_ALWAYS(a_count_bound, clk, arst_n, count_q <= CNT_W'(STACK_DEPTH))
	`ASSERT_NEXT(a_ovf_sticky, clk, arst_n, ovf_q, ovf_q)

endmodule

// ----- rtl/core/active_triangle_span_fill.sv -----
// ----------------------------------------------------------------------------
// active_triangle_span_fill
// ordered list of triangles active on the scanline, top color per pixel
// ----------------------------------------------------------------------------
// Every request runs a capture step, which registers it together with a
// parallel compare of its id against all stack cells, and then an execute
// step, which applies the removal shift or push (or sets the overflow flag
// when the stack is full), or loads the pixel result. The next request is
// taken in the cycle after that. A pixel request holds in its execute step
// while the previous result still waits in the output register. The stack
// holds up to 64 entries; its top lives in cell zero, so a pixel reads a fixed cell.
`include "assert_macros.svh"

module active_triangle_span_fill (
	input  logic        clk,
	input  logic        arst_n,
	atsf_req_if.sink    req,
	atsf_res_if.source  res
);
	import atsf_pkg::*;

	atsf_cmd_t cmd;
	atsf_sts_t sts;

	atsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (res.valid),
		.out_ready (res.ready),
		.cmd       (cmd),
		.sts       (sts)
	);

	atsf_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_type    (req.req_type),
		.triangle_id (req.triangle_id),
		.tri_color   (req.tri_color),
		.pixel_color (res.pixel_color),
		.covered     (res.covered),
		.overflowed  (res.overflowed)
	);

	`ASSERT_ALWAYS(a_one_cmd, clk, arst_n, $onehot0({cmd.capture, cmd.toggle, cmd.pixel}))

endmodule
